FILE: design/ptt_pkg.sv
// ---------------------------------------------------------------------------
// ptt_pkg - shared types and tile functions
// Command codes, request/result structs and the fixed bit permutations
// used on the 8x8 2bpp planar tile.
// ---------------------------------------------------------------------------
`default_nettype none

package ptt_pkg;

  localparam int unsigned PlaneW = 64;

  // Tile commands
  typedef enum logic [3:0] {
    CMD_LOAD        = 4'd0,
    CMD_SET_PIXEL   = 4'd1,
    CMD_GET_PIXEL   = 4'd2,
    CMD_FILL        = 4'd3,
    CMD_HMIRROR     = 4'd4,
    CMD_VMIRROR     = 4'd5,
    CMD_ROTATE_CW   = 4'd6,
    CMD_ROTATE_CCW  = 4'd7,
    CMD_COMPARE     = 4'd8
  } cmd_t;

  // Configuration register indexes
  localparam logic REG_FILL_COLOR = 1'b0;

  typedef struct packed {
    logic [PlaneW-1:0] high_plane_in;
    logic [PlaneW-1:0] low_plane_in;
    logic [1:0]        pixel_color;
    logic [2:0]        pixel_y;
    logic [2:0]        pixel_x;
    cmd_t              command;
  } req_t;

  typedef struct packed {
    logic              tiles_match;
    logic [1:0]        read_color;
    logic [PlaneW-1:0] high_plane_out;
    logic [PlaneW-1:0] low_plane_out;
  } res_t;

  // Plane bit of pixel (x, y): row byte y, pixel x at bit 7-x
  function automatic logic [5:0] bit_pos(input logic [2:0] x, input logic [2:0] y);
    bit_pos = {y, ~x};
  endfunction

  // Reverse the bits inside every byte
  function automatic logic [PlaneW-1:0] mirror_rows(input logic [PlaneW-1:0] p);
    logic [PlaneW-1:0] r;
    r = '0;
    for (int row = 0; row < 8; row++) begin
      for (int i = 0; i < 8; i++) begin
        r[8*row + i] = p[8*row + 7 - i];
      end
    end
    mirror_rows = r;
  endfunction

  // Swap byte r with byte 7-r
  function automatic logic [PlaneW-1:0] mirror_cols(input logic [PlaneW-1:0] p);
    logic [PlaneW-1:0] r;
    r = '0;
    for (int row = 0; row < 8; row++) begin
      r[8*(7-row) +: 8] = p[8*row +: 8];
    end
    mirror_cols = r;
  endfunction

  // cw: new(x,y) = old(y,7-x); ccw: new(x,y) = old(7-y,x)
  function automatic logic [PlaneW-1:0] rotate_plane(input logic [PlaneW-1:0] p,
                                                     input logic cw);
    logic [PlaneW-1:0] r;
    r = '0;
    for (int y = 0; y < 8; y++) begin
      for (int x = 0; x < 8; x++) begin
        if (cw) begin
          r[8*y + 7 - x] = p[8*(7-x) + 7 - y];
        end else begin
          r[8*y + 7 - x] = p[8*x + y];
        end
      end
    end
    rotate_plane = r;
  endfunction

endpackage

`default_nettype wire

FILE: design/ptt_cfg.sv
// ---------------------------------------------------------------------------
// ptt_cfg - configuration registers
// APB-style register port holding the fill color.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_cfg
  import ptt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output logic [1:0]       fill_color
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // Fill color register, word index taken from paddr[2]
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_color <= 2'd0;
    end else if (wr_en && paddr[2] == REG_FILL_COLOR) begin
      fill_color <= pwdata[1:0];
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_FILL_COLOR) begin
      prdata = {30'd0, fill_color};
    end
  end

endmodule

`default_nettype wire

FILE: design/ptt_core.sv
// ---------------------------------------------------------------------------
// ptt_core - tile state and transform stage
// Applies one command per cycle to the stored planes while the result
// register is free or being drained, and registers the result for the output channel.
// ---------------------------------------------------------------------------
`default_nettype none

module ptt_core
  import ptt_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       req_valid,
  input  wire req_t       req,
  output logic            req_take,
  input  wire logic [1:0] fill_color,
  output logic            res_valid,
  input  wire logic       res_ready,
  output res_t            res
);

  logic [PlaneW-1:0] low_plane, low_plane_next;
  logic [PlaneW-1:0] high_plane, high_plane_next;
  logic [1:0]        color_next;
  logic              match_next;
  logic [5:0]        pos;

  // Stage advances when the result register is free or being drained
  assign req_take = req_valid && (!res_valid || res_ready);
  assign pos      = bit_pos(req.pixel_x, req.pixel_y);

  // Command decode
  always_comb begin
    low_plane_next  = low_plane;
    high_plane_next = high_plane;
    color_next      = 2'd0;
    match_next      = 1'b0;
    case (req.command)
      CMD_LOAD: begin
        low_plane_next  = req.low_plane_in;
        high_plane_next = req.high_plane_in;
      end
      CMD_SET_PIXEL: begin
        low_plane_next[pos]  = req.pixel_color[0];
        high_plane_next[pos] = req.pixel_color[1];
      end
      CMD_GET_PIXEL: begin
        color_next = {high_plane[pos], low_plane[pos]};
      end
      CMD_FILL: begin
        low_plane_next  = {PlaneW{fill_color[0]}};
        high_plane_next = {PlaneW{fill_color[1]}};
      end
      CMD_HMIRROR: begin
        low_plane_next  = mirror_rows(low_plane);
        high_plane_next = mirror_rows(high_plane);
      end
      CMD_VMIRROR: begin
        low_plane_next  = mirror_cols(low_plane);
        high_plane_next = mirror_cols(high_plane);
      end
      CMD_ROTATE_CW: begin
        low_plane_next  = rotate_plane(low_plane, 1'b1);
        high_plane_next = rotate_plane(high_plane, 1'b1);
      end
      CMD_ROTATE_CCW: begin
        low_plane_next  = rotate_plane(low_plane, 1'b0);
        high_plane_next = rotate_plane(high_plane, 1'b0);
      end
      CMD_COMPARE: begin
        match_next = (req.low_plane_in == low_plane) &&
                     (req.high_plane_in == high_plane);
      end
      default: begin
        // unused codes leave the tile alone
      end
    endcase
  end

  // Tile state
  always_ff @(posedge clk) begin
    if (rst) begin
      low_plane  <= '0;
      high_plane <= '0;
    end else if (req_take) begin
      low_plane  <= low_plane_next;
      high_plane <= high_plane_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (req_take) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res.low_plane_out  <= low_plane_next;
      res.high_plane_out <= high_plane_next;
      res.read_color     <= color_next;
      res.tiles_match    <= match_next;
    end
  end

  // Checks
  a_fill_pattern: assert property (@(posedge clk) disable iff (rst)
    req_take && req.command == CMD_FILL |=>
      low_plane == {PlaneW{$past(fill_color[0])}} &&
      high_plane == {PlaneW{$past(fill_color[1])}})
    else $error("fill did not produce uniform planes");

  a_compare_keeps_tile: assert property (@(posedge clk) disable iff (rst)
    req_take && req.command == CMD_COMPARE |=> $stable(low_plane) && $stable(high_plane))
    else $error("compare changed the tile");

  a_match_only_compare: assert property (@(posedge clk) disable iff (rst)
    req_take && req.command != CMD_COMPARE |=> !res.tiles_match)
    else $error("match flag set outside compare");

  a_color_only_get: assert property (@(posedge clk) disable iff (rst)
    req_take && req.command != CMD_GET_PIXEL |=> res.read_color == 2'd0)
    else $error("read color set outside get pixel");

  a_result_matches_tile: assert property (@(posedge clk) disable iff (rst)
    req_take |=> res.low_plane_out == low_plane && res.high_plane_out == high_plane)
    else $error("result planes differ from stored tile");

endmodule

`default_nettype wire

FILE: design/planar_tile_transform_unit.sv
// ---------------------------------------------------------------------------
// planar_tile_transform_unit - 8x8 2bpp planar tile flip/rotate unit
// Holds one tile in two 64-bit bit planes and applies one command per
// request: load, set/get pixel, fill, mirror, rotate, compare.
// ---------------------------------------------------------------------------
// Usage:
//   Requests enter on s_tvalid/s_tready; s_tuser carries the command and
//   s_tdata the pixel fields and the two plane inputs. Every request gives
//   one result on m_tvalid/m_tready with the planes after the command, the
//   color read by get pixel and the compare flag.
//   Flow: an accepted request sits in the input register; its result is
//   then registered in the result register and shown from then on.
//   Throughput: one request per cycle while m_tready is high; the command logic
//   between the input and result registers finishes a request each such cycle.
//   Stall: while m_tready is low the result waits in its register, one more
//   request is held in the input register, then s_tready drops.
//   Reset (rst, synchronous): tile planes, fill color and both valid flags
//   clear. Fill color is written over the APB port at address 0.
// ---------------------------------------------------------------------------
`default_nettype none

module planar_tile_transform_unit
  import ptt_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  // request stream
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [2:0] pixel_x, [5:3] pixel_y, [7:6] pixel_color,
  // [71:8] low_plane_in, [135:72] high_plane_in
  input  wire logic [135:0] s_tdata,
  // [3:0] command
  input  wire logic [3:0]   s_tuser,
  // result stream
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [63:0] low_plane_out, [127:64] high_plane_out, [129:128] read_color,
  // [130] tiles_match, [135:131] zero
  output logic [135:0]      m_tdata,
  // configuration
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic       in_valid;
  req_t       in_req;
  logic       req_take;
  logic [1:0] fill_color;
  res_t       res;

  // Input register
  assign s_tready = !in_valid || req_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (req_take) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_req <= {s_tdata, cmd_t'(s_tuser)};
    end
  end

  ptt_cfg u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .fill_color (fill_color)
  );

  ptt_core u_core (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (in_valid),
    .req        (in_req),
    .req_take   (req_take),
    .fill_color (fill_color),
    .res_valid  (m_tvalid),
    .res_ready  (m_tready),
    .res        (res)
  );

  assign m_tdata = {5'd0, res};

endmodule

`default_nettype wire

FILE: tb/tb_planar_tile_transform_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_planar_tile_transform_unit - self-checking tile unit testbench
// Sends tile commands on the request stream and checks every result field
// against a pixel-level model of the tile kept here. Directed rows cover
// reset, extremes and unused codes; random phases follow, each setting a
// fill color and a pattern of sender gaps and receiver stalls, from none to both.
// ---------------------------------------------------------------------------
module tb_planar_tile_transform_unit;
  import ptt_pkg::*;

  localparam int unsigned ItemsPerPhase = 113;
  localparam int unsigned NumPhases     = 10;
  localparam int unsigned CycleLimit    = 200000;
  localparam int unsigned SpareRegIndex = 1;
  localparam logic [2:0]  FillColorAddr = 3'(4 * REG_FILL_COLOR);
  localparam logic [2:0]  SpareAddr     = 3'(4 * SpareRegIndex);
  localparam logic [3:0]  FirstSpareCode = CMD_COMPARE + 4'd1;
  localparam logic [3:0]  LastSpareCode  = 4'hF;
  localparam logic [63:0] PatLo   = 64'h0123_4567_89AB_CDEF;
  localparam logic [63:0] PatHi   = 64'hFEDC_BA98_7654_3210;
  localparam logic [63:0] AllOnes = '1;

  // directed row: request plus an optional hand-typed result
  typedef struct {
    req_t rq;
    bit   golden;
    res_t want;
  } tile_vector_t;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // [2:0] pixel_x, [5:3] pixel_y, [7:6] pixel_color,
  // [71:8] low_plane_in, [135:72] high_plane_in
  logic [135:0] s_tdata;
  // [3:0] command
  logic [3:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // [63:0] low_plane_out, [127:64] high_plane_out, [129:128] read_color,
  // [130] tiles_match, [135:131] zero
  logic [135:0] m_tdata;
  logic         psel;
  logic         penable;
  logic         pwrite;
  logic [2:0]   paddr;
  logic [31:0]  pwdata;
  logic [31:0]  prdata;
  logic         pready;

  // model state
  logic [63:0]  tile_lo;
  logic [63:0]  tile_hi;
  logic [1:0]   fill_shadow;
  res_t         tile_expect[$];
  tile_vector_t directed_rows[$];
  int           mismatch_count = 0;
  int unsigned  src_gap_max = 3;
  int unsigned  sink_stall_max = 3;
  int unsigned  cycle_count = 0;

  planar_tile_transform_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 50 MHz clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hang guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // plane bit of pixel (x, y)
  function automatic int unsigned plane_bit(int unsigned x, int unsigned y);
    return 8 * y + 7 - x;
  endfunction

  // every geometric op as a per-pixel source lookup
  function automatic logic [63:0] remap_plane(logic [63:0] p, cmd_t op);
    logic [63:0] r;
    int unsigned x, y, sx, sy;
    r = '0;
    for (y = 0; y < 8; y++) begin
      for (x = 0; x < 8; x++) begin
        case (op)
          CMD_HMIRROR: begin
            sx = 7 - x;
            sy = y;
          end
          CMD_VMIRROR: begin
            sx = x;
            sy = 7 - y;
          end
          CMD_ROTATE_CW: begin
            sx = y;
            sy = 7 - x;
          end
          default: begin
            sx = 7 - y;
            sy = x;
          end
        endcase
        r[plane_bit(x, y)] = p[plane_bit(sx, sy)];
      end
    end
    return r;
  endfunction

  // apply one request to the model tile, return the result it gives
  function automatic res_t predict_tile(req_t rq);
    res_t r;
    int unsigned b;
    r = '0;
    b = plane_bit(rq.pixel_x, rq.pixel_y);
    case (rq.command)
      CMD_LOAD: begin
        tile_lo = rq.low_plane_in;
        tile_hi = rq.high_plane_in;
      end
      CMD_SET_PIXEL: begin
        tile_lo[b] = rq.pixel_color[0];
        tile_hi[b] = rq.pixel_color[1];
      end
      CMD_GET_PIXEL: r.read_color = {tile_hi[b], tile_lo[b]};
      CMD_FILL: begin
        tile_lo = {64{fill_shadow[0]}};
        tile_hi = {64{fill_shadow[1]}};
      end
      CMD_HMIRROR, CMD_VMIRROR, CMD_ROTATE_CW, CMD_ROTATE_CCW: begin
        tile_lo = remap_plane(tile_lo, rq.command);
        tile_hi = remap_plane(tile_hi, rq.command);
      end
      CMD_COMPARE: begin
        r.tiles_match = (rq.low_plane_in == tile_lo) && (rq.high_plane_in == tile_hi);
      end
      default: ;
    endcase
    r.low_plane_out  = tile_lo;
    r.high_plane_out = tile_hi;
    return r;
  endfunction

  function automatic req_t make_req(logic [3:0] code, int unsigned x, int unsigned y,
                                    int unsigned color, logic [63:0] lo, logic [63:0] hi);
    req_t rq;
    rq.command       = cmd_t'(code);
    rq.pixel_x       = 3'(x);
    rq.pixel_y       = 3'(y);
    rq.pixel_color   = 2'(color);
    rq.low_plane_in  = lo;
    rq.high_plane_in = hi;
    return rq;
  endfunction

  function automatic res_t make_res(logic [63:0] lo, logic [63:0] hi,
                                    int unsigned color, int unsigned match);
    res_t r;
    r.low_plane_out  = lo;
    r.high_plane_out = hi;
    r.read_color     = 2'(color);
    r.tiles_match    = 1'(match);
    return r;
  endfunction

  function automatic void add_row(req_t rq);
    tile_vector_t v;
    v.rq     = rq;
    v.golden = 1'b0;
    v.want   = '0;
    directed_rows.push_back(v);
  endfunction

  function automatic void add_golden(req_t rq, res_t want);
    tile_vector_t v;
    v.rq     = rq;
    v.golden = 1'b1;
    v.want   = want;
    directed_rows.push_back(v);
  endfunction

  // random request, mostly valid commands with random content
  function automatic req_t random_tile_request();
    int unsigned pick;
    logic [63:0] lo, hi;
    logic [3:0]  code;
    pick = $urandom_range(0, 99);
    lo   = {$urandom, $urandom};
    hi   = {$urandom, $urandom};
    if (pick < 12)      code = CMD_LOAD;
    else if (pick < 24) code = CMD_SET_PIXEL;
    else if (pick < 36) code = CMD_GET_PIXEL;
    else if (pick < 42) code = CMD_FILL;
    else if (pick < 52) code = CMD_HMIRROR;
    else if (pick < 62) code = CMD_VMIRROR;
    else if (pick < 72) code = CMD_ROTATE_CW;
    else if (pick < 82) code = CMD_ROTATE_CCW;
    else if (pick < 94) code = CMD_COMPARE;
    else                code = 4'($urandom_range(FirstSpareCode, LastSpareCode));
    // solid planes now and then
    if (code == CMD_LOAD) begin
      case ($urandom_range(0, 7))
        0: lo = '0;
        1: hi = '1;
        2: begin
          lo = '1;
          hi = '1;
        end
        default: ;
      endcase
    end
    // compare: exact match, single-bit miss, or random
    if (code == CMD_COMPARE) begin
      case ($urandom_range(0, 3))
        0, 1: begin
          lo = tile_lo;
          hi = tile_hi;
        end
        2: begin
          lo = tile_lo;
          hi = tile_hi;
          if ($urandom_range(0, 1)) lo = lo ^ (64'd1 << $urandom_range(0, 63));
          else hi = hi ^ (64'd1 << $urandom_range(0, 63));
        end
        default: ;
      endcase
    end
    return make_req(code, $urandom_range(0, 7), $urandom_range(0, 7),
                    $urandom_range(0, 3), lo, hi);
  endfunction

  // present one request, wait for the handshake, log what it should return
  task automatic send_request(req_t rq, bit golden, res_t want);
    int unsigned gap;
    res_t predicted;
    gap = $urandom_range(0, src_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {rq.high_plane_in, rq.low_plane_in, rq.pixel_color, rq.pixel_y,
                 rq.pixel_x};
    s_tuser  <= rq.command;
    do @(posedge clk); while (!s_tready);
    predicted = predict_tile(rq);
    tile_expect.push_back(golden ? want : predicted);
  endtask

  // stop sending and let every outstanding result come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (tile_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (addr == FillColorAddr) fill_shadow = data[1:0];
    // return to idle before the next transfer
    @(posedge clk);
  endtask

  // read fill color back and compare with the model copy
  task automatic fill_readback();
    logic [31:0] data;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= FillColorAddr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (data[1:0] !== fill_shadow) begin
      $error("fill_color: expected %0d, got %0d", fill_shadow, data[1:0]);
      mismatch_count++;
    end
    // return to idle before the next transfer
    @(posedge clk);
  endtask

  // compare one result with the oldest expectation
  task automatic check_result(logic [135:0] data);
    res_t got, want;
    got = res_t'(data[130:0]);
    if (tile_expect.size() == 0) begin
      $error("unexpected result: low_plane_out %h high_plane_out %h",
             got.low_plane_out, got.high_plane_out);
      mismatch_count++;
    end else begin
      want = tile_expect.pop_front();
      if (got.low_plane_out !== want.low_plane_out) begin
        $error("low_plane_out: expected %h, got %h", want.low_plane_out, got.low_plane_out);
        mismatch_count++;
      end
      if (got.high_plane_out !== want.high_plane_out) begin
        $error("high_plane_out: expected %h, got %h", want.high_plane_out,
               got.high_plane_out);
        mismatch_count++;
      end
      if (got.read_color !== want.read_color) begin
        $error("read_color: expected %0d, got %0d", want.read_color, got.read_color);
        mismatch_count++;
      end
      if (got.tiles_match !== want.tiles_match) begin
        $error("tiles_match: expected %0d, got %0d", want.tiles_match, got.tiles_match);
        mismatch_count++;
      end
    end
  endtask

  // result side: random stall per result, then take it
  initial begin
    int unsigned stall;
    m_tready <= 1'b0;
    wait (rst === 1'b1);
    wait (rst === 1'b0);
    @(posedge clk);
    forever begin
      stall = $urandom_range(0, sink_stall_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      check_result(m_tdata);
    end
  end

  // request side and run control
  initial begin
    tile_vector_t row;
    logic [1:0]   color;
    rst     <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    tile_lo = '0;
    tile_hi = '0;
    fill_shadow = '0;

    // directed rows: reset state, extremes, unused codes, corner pixels
    add_golden(make_req(CMD_GET_PIXEL, 7, 7, 3, PatLo, PatHi), make_res('0, '0, 0, 0));
    add_golden(make_req(CMD_COMPARE, 0, 0, 0, '0, '0), make_res('0, '0, 0, 1));
    add_golden(make_req(CMD_COMPARE, 0, 0, 0, '0, 64'd1), make_res('0, '0, 0, 0));
    add_golden(make_req(CMD_LOAD, 7, 0, 3, AllOnes, AllOnes),
               make_res(AllOnes, AllOnes, 0, 0));
    add_golden(make_req(CMD_GET_PIXEL, 0, 0, 0, '0, '0), make_res(AllOnes, AllOnes, 3, 0));
    add_golden(make_req(CMD_FILL, 7, 7, 3, AllOnes, AllOnes), make_res('0, '0, 0, 0));
    add_golden(make_req(CMD_LOAD, 0, 7, 0, PatLo, PatHi), make_res(PatLo, PatHi, 0, 0));
    add_golden(make_req(CMD_COMPARE, 0, 0, 0, PatLo, PatHi), make_res(PatLo, PatHi, 0, 1));
    add_golden(make_req(CMD_COMPARE, 0, 0, 0, PatLo ^ {1'b1, 63'd0}, PatHi),
               make_res(PatLo, PatHi, 0, 0));
    add_golden(make_req(FirstSpareCode, 7, 7, 3, AllOnes, AllOnes),
               make_res(PatLo, PatHi, 0, 0));
    add_golden(make_req(LastSpareCode, 7, 7, 3, PatLo, PatHi),
               make_res(PatLo, PatHi, 0, 0));
    add_row(make_req(CMD_HMIRROR, 7, 7, 3, AllOnes, AllOnes));
    add_row(make_req(CMD_VMIRROR, 0, 0, 0, AllOnes, '0));
    add_row(make_req(CMD_ROTATE_CW, 7, 0, 2, '0, AllOnes));
    add_row(make_req(CMD_ROTATE_CCW, 0, 7, 1, PatHi, PatLo));
    add_row(make_req(CMD_SET_PIXEL, 0, 0, 2, '0, '0));
    add_row(make_req(CMD_SET_PIXEL, 7, 7, 1, AllOnes, AllOnes));
    add_row(make_req(CMD_SET_PIXEL, 7, 0, 3, '0, '0));
    add_row(make_req(CMD_SET_PIXEL, 0, 7, 0, AllOnes, AllOnes));
    add_row(make_req(CMD_GET_PIXEL, 0, 0, 3, '0, '0));
    add_row(make_req(CMD_GET_PIXEL, 7, 7, 0, '0, '0));
    add_row(make_req(CMD_GET_PIXEL, 7, 0, 0, '0, '0));
    add_row(make_req(CMD_GET_PIXEL, 0, 7, 0, '0, '0));
    add_golden(make_req(CMD_LOAD, 3, 5, 3, '0, '0), make_res('0, '0, 0, 0));
    add_golden(make_req(CMD_SET_PIXEL, 3, 5, 3, AllOnes, AllOnes),
               make_res(64'd1 << 44, 64'd1 << 44, 0, 0));

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill color comes out of reset as zero
    fill_readback();
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_request(row.rq, row.golden, row.want);
    end
    wait_drain();

    // random phases, fill color and idling pattern change per phase
    for (int unsigned phase = 0; phase < NumPhases; phase++) begin
      color = 2'((3 * phase + 3) % 4);
      apb_write(FillColorAddr, ($urandom & ~32'h3) | 32'(color));
      if (phase == 0) apb_write(SpareAddr, $urandom);
      fill_readback();
      case (phase % 4)
        0: begin
          src_gap_max    = 0;
          sink_stall_max = 0;
        end
        1: begin
          src_gap_max    = 7;
          sink_stall_max = 7;
        end
        2: begin
          src_gap_max    = 0;
          sink_stall_max = 7;
        end
        default: begin
          src_gap_max    = 7;
          sink_stall_max = 0;
        end
      endcase
      for (int unsigned n = 0; n < ItemsPerPhase; n++) begin
        // hold off mid-phase until the pipe is empty
        if (n == ItemsPerPhase / 2) wait_drain();
        send_request(random_tile_request(), 1'b0, '0);
      end
      wait_drain();
    end

    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
